@@ rtl/affine_inverse_coordinate_map_defines.svh @@
// ----------------------------------------------------------------------------
// Affine inverse coordinate map: assertion macros
// Clocked assertion helpers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef AFFINE_INVERSE_COORDINATE_MAP_DEFINES_SVH
`define AFFINE_INVERSE_COORDINATE_MAP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define AICM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aicm assertion failed");
// Checked on every rising edge, reset included.
`define AICM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("aicm assertion failed");
`else
`define AICM_ASSERT(lbl, prop)
`define AICM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/aicm_pkg.sv @@
// ----------------------------------------------------------------------------
// aicm_pkg
// Constants, types and width helpers of the affine inverse coordinate map.
// ----------------------------------------------------------------------------
package aicm_pkg;

  // Input coordinates are unsigned Q0.16 held in 17 bits.
  localparam int NORM_W    = 17;
  // Fraction bits of the Q16.16 result.
  localparam int FRAC_BITS = 16;
  // Result width.
  localparam int OUT_W     = 32;
  // Quotient bits produced by the divider before saturation.
  localparam int QUOT_BITS = 33;
  // Determinant magnitudes below this (Q.32 units) count as singular.
  localparam int SING_LIMIT = 4295;

  localparam logic [31:0] SING_VALUE  = 32'hFFFF_0000;
  localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG     = 32'h8000_0000;
  localparam logic [31:0] COEF_ONE    = 32'h0001_0000;
  localparam logic [31:0] DIMS_RESET  = 32'h0001_0001;

  // Register map, in register index order.
  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_COEF_E   = 3'd4,
    REG_COEF_F   = 3'd5,
    REG_SRC_DIMS = 3'd6,
    REG_DST_DIMS = 3'd7
  } reg_idx_e;

  // Per-axis side information that travels with the divider operands.
  typedef struct packed {
    logic singular;
    logic neg;
    logic div_zero;
    logic num_zero;
  } axis_flags_t;

  // Width of a numerator (e*dx - b*dy) as a signed value.
  function automatic int num_width(int cw, int db);
    int dst_w;
    int dx_w;
    dst_w = NORM_W + db;
    dx_w  = ((dst_w + 1) > cw ? (dst_w + 1) : cw) + 1;
    return cw + dx_w + 1;
  endfunction

  // Width of the divisor |det| * (size - 1).
  function automatic int den_width(int cw, int db);
    return 2 * cw + 1 + db;
  endfunction

endpackage

@@ rtl/aicm_front.sv @@
// ----------------------------------------------------------------------------
// aicm_front
// Five-stage front end: scales the destination point, forms the determinant
// and both Cramer numerators, and prepares magnitudes and divisors.
// ----------------------------------------------------------------------------
module aicm_front #(
  parameter int COEF_WIDTH = 32,
  parameter int DIM_BITS   = 16,
  parameter int NUM_W      = aicm_pkg::num_width(32, 16),
  parameter int DEN_W      = aicm_pkg::den_width(32, 16)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [aicm_pkg::NORM_W-1:0]    norm_x_i,
  input  logic [aicm_pkg::NORM_W-1:0]    norm_y_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_c_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_d_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_e_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_f_i,
  input  logic [31:0]                    src_dims_i,
  input  logic [31:0]                    dst_dims_i,
  output logic                           valid_o,
  output logic [NUM_W-1:0]               num_x_o,
  output logic [DEN_W-1:0]               den_x_o,
  output aicm_pkg::axis_flags_t          flags_x_o,
  output logic [NUM_W-1:0]               num_y_o,
  output logic [DEN_W-1:0]               den_y_o,
  output aicm_pkg::axis_flags_t          flags_y_o
);

  localparam int CW    = COEF_WIDTH;
  localparam int DST_W = aicm_pkg::NORM_W + DIM_BITS;
  localparam int DX_W  = NUM_W - CW - 1;
  localparam int PX_W  = CW + DX_W;
  localparam int DET_W = 2 * CW + 1;

  // Sizes minus one; a size of zero counts as one.
  logic [DIM_BITS-1:0] dwx, dwy, swx, swy;
  logic [DIM_BITS-1:0] dwx_m1, dwy_m1, swx_m1, swy_m1;

  assign dwx = dst_dims_i[DIM_BITS-1:0];
  assign dwy = dst_dims_i[16 +: DIM_BITS];
  assign swx = src_dims_i[DIM_BITS-1:0];
  assign swy = src_dims_i[16 +: DIM_BITS];
  assign dwx_m1 = (dwx == '0) ? '0 : dwx - 1'b1;
  assign dwy_m1 = (dwy == '0) ? '0 : dwy - 1'b1;
  assign swx_m1 = (swx == '0) ? '0 : swx - 1'b1;
  assign swy_m1 = (swy == '0) ? '0 : swy - 1'b1;

  // Valid bits of the five stages.
  logic [4:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // Stage 1: destination point in pixels, Q.16.
  logic [DST_W-1:0] dst_x_d, dst_y_d, dst_x_q, dst_y_q;

  assign dst_x_d = DST_W'(norm_x_i) * DST_W'(dwx_m1);
  assign dst_y_d = DST_W'(norm_y_i) * DST_W'(dwy_m1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dst_x_q <= dst_x_d;
      dst_y_q <= dst_y_d;
    end
  end

  // Stage 2: offsets removed, determinant products.
  logic signed [DX_W-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic signed [2*CW-1:0]   pae_d, pbd_d, pae_q, pbd_q;

  assign dx_d  = $signed(DX_W'(dst_x_q)) - DX_W'(coef_c_i);
  assign dy_d  = $signed(DX_W'(dst_y_q)) - DX_W'(coef_f_i);
  assign pae_d = coef_a_i * coef_e_i;
  assign pbd_d = coef_b_i * coef_d_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      pae_q <= pae_d;
      pbd_q <= pbd_d;
    end
  end

  // Stage 3: numerator products and the determinant.
  logic signed [PX_W-1:0]  pex_d, pbdy_d, pady_d, pddx_d;
  logic signed [PX_W-1:0]  pex_q, pbdy_q, pady_q, pddx_q;
  logic signed [DET_W-1:0] det_d, det_q;

  assign pex_d  = PX_W'(coef_e_i) * PX_W'(dx_q);
  assign pbdy_d = PX_W'(coef_b_i) * PX_W'(dy_q);
  assign pady_d = PX_W'(coef_a_i) * PX_W'(dy_q);
  assign pddx_d = PX_W'(coef_d_i) * PX_W'(dx_q);
  assign det_d  = DET_W'(pae_q) - DET_W'(pbd_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pex_q  <= pex_d;
      pbdy_q <= pbdy_d;
      pady_q <= pady_d;
      pddx_q <= pddx_d;
      det_q  <= det_d;
    end
  end

  // Stage 4: numerators, determinant magnitude and the singular test.
  logic signed [NUM_W-1:0] numx_d, numy_d, numx_q, numy_q;
  logic [DET_W-1:0]        adet_d, adet_q;
  logic                    dneg_q, sing_d, sing_q;

  assign numx_d = NUM_W'(pex_q) - NUM_W'(pbdy_q);
  assign numy_d = NUM_W'(pady_q) - NUM_W'(pddx_q);
  assign adet_d = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
  assign sing_d = adet_d < DET_W'(aicm_pkg::SING_LIMIT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx_q <= numx_d;
      numy_q <= numy_d;
      adet_q <= adet_d;
      dneg_q <= det_q[DET_W-1];
      sing_q <= sing_d;
    end
  end

  // Stage 5: magnitudes, signs and divisors for both axes.
  logic [NUM_W-1:0]      magx_d, magy_d;
  logic [DEN_W-1:0]      denx_d, deny_d;
  aicm_pkg::axis_flags_t fx_d, fy_d;

  assign magx_d = numx_q[NUM_W-1] ? NUM_W'(-numx_q) : NUM_W'(numx_q);
  assign magy_d = numy_q[NUM_W-1] ? NUM_W'(-numy_q) : NUM_W'(numy_q);
  assign denx_d = DEN_W'(adet_q) * DEN_W'(swx_m1);
  assign deny_d = DEN_W'(adet_q) * DEN_W'(swy_m1);

  always_comb begin
    fx_d.singular = sing_q;
    fx_d.neg      = numx_q[NUM_W-1] ^ dneg_q;
    fx_d.div_zero = (swx_m1 == '0);
    fx_d.num_zero = (numx_q == '0);
    fy_d.singular = sing_q;
    fy_d.neg      = numy_q[NUM_W-1] ^ dneg_q;
    fy_d.div_zero = (swy_m1 == '0);
    fy_d.num_zero = (numy_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_x_o   <= magx_d;
      num_y_o   <= magy_d;
      den_x_o   <= denx_d;
      den_y_o   <= deny_d;
      flags_x_o <= fx_d;
      flags_y_o <= fy_d;
    end
  end

  assign valid_o = v_q[4];

endmodule

@@ rtl/aicm_div.sv @@
// ----------------------------------------------------------------------------
// aicm_div
// Pipelined restoring divider, one quotient bit per stage, followed by
// round-half-away, sign and saturation for one output axis.
// ----------------------------------------------------------------------------
module aicm_div #(
  parameter int NUM_W = aicm_pkg::num_width(32, 16),
  parameter int DEN_W = aicm_pkg::den_width(32, 16)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  input  aicm_pkg::axis_flags_t         flags_i,
  output logic                          valid_o,
  output logic [aicm_pkg::OUT_W-1:0]    res_o,
  output logic                          fault_o,
  output logic                          singular_o
);

  localparam int QB   = aicm_pkg::QUOT_BITS;
  localparam int NW   = NUM_W + aicm_pkg::FRAC_BITS;
  localparam int RW   = DEN_W + QB;
  localparam int CMPW = (NW > RW ? NW : RW) + 1;

  logic [RW-1:0]         r_q   [QB+1];
  logic [QB-1:0]         q_q   [QB+1];
  logic [DEN_W-1:0]      d_q   [QB+1];
  aicm_pkg::axis_flags_t f_q   [QB+1];
  logic [QB:0]           ovf_q;
  logic [QB+1:0]         v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB:0], valid_i};
    end
  end

  // Entry stage: scale the numerator and catch quotients beyond QB bits.
  logic [NW-1:0] n_full;
  logic          ovf_d;

  assign n_full = {num_i, {aicm_pkg::FRAC_BITS{1'b0}}};
  assign ovf_d  = CMPW'(n_full) >= CMPW'({den_i, {QB{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= ovf_d ? '0 : RW'(n_full);
      q_q[0]   <= '0;
      d_q[0]   <= den_i;
      f_q[0]   <= flags_i;
      ovf_q[0] <= ovf_d;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int SH = QB - k;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(d_q[k-1]) << SH;
    assign ge  = r_q[k-1] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? r_q[k-1] - dsh : r_q[k-1];
        q_q[k]   <= ge ? (q_q[k-1] | (QB'(1) << SH)) : q_q[k-1];
        d_q[k]   <= d_q[k-1];
        f_q[k]   <= f_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // Final stage: rounding, sign, saturation and special cases.
  logic                       up;
  logic [QB:0]                qr;
  logic [aicm_pkg::OUT_W-1:0] res_d;
  logic                       fault_d;
  aicm_pkg::axis_flags_t      ff;

  assign ff = f_q[QB];
  assign up = (RW+1)'({r_q[QB], 1'b0}) >= (RW+1)'(d_q[QB]);
  assign qr = (QB+1)'(q_q[QB]) + (QB+1)'(up);

  always_comb begin
    res_d   = '0;
    fault_d = 1'b0;
    if (ff.singular) begin
      res_d = aicm_pkg::SING_VALUE;
    end else if (ff.div_zero) begin
      fault_d = 1'b1;
      if (ff.num_zero) begin
        res_d = '0;
      end else begin
        res_d = ff.neg ? aicm_pkg::SAT_NEG : aicm_pkg::SAT_POS;
      end
    end else if (ovf_q[QB]) begin
      fault_d = 1'b1;
      res_d   = ff.neg ? aicm_pkg::SAT_NEG : aicm_pkg::SAT_POS;
    end else if (ff.neg) begin
      if (qr > (QB+1)'(aicm_pkg::SAT_NEG)) begin
        fault_d = 1'b1;
        res_d   = aicm_pkg::SAT_NEG;
      end else begin
        res_d = aicm_pkg::OUT_W'(-qr[aicm_pkg::OUT_W-1:0]);
      end
    end else begin
      if (qr > (QB+1)'(aicm_pkg::SAT_POS)) begin
        fault_d = 1'b1;
        res_d   = aicm_pkg::SAT_POS;
      end else begin
        res_d = qr[aicm_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o      <= res_d;
      fault_o    <= fault_d;
      singular_o <= ff.singular;
    end
  end

  assign valid_o = v_q[QB+1];

endmodule

@@ rtl/affine_inverse_coordinate_map.sv @@
// Pipeline: 5 front-end stages and 35 divider stages (entry, 33 quotient bits,
// round and saturate) at the default parameters; the divider depth follows
// aicm_pkg::QUOT_BITS.
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset: asynchronous, active low; clears valid bits and loads register resets.
// ----------------------------------------------------------------------------
// affine_inverse_coordinate_map
// Maps a normalized destination point through the inverse of a Q16.16 affine
// matrix to a normalized source point, with singular and range flags.
// ----------------------------------------------------------------------------
`include "affine_inverse_coordinate_map_defines.svh"

module affine_inverse_coordinate_map #(
  parameter int COEF_WIDTH = 32,
  parameter int DIM_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // norm_x [16:0], norm_y [33:17], zeros above
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // src_norm_x [31:0], src_norm_y [63:32]
  output logic [1:0]  m_axis_tuser,   // singular [0], range_fault [1]
  // Configuration port.
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [(COEF_WIDTH > 32 ? 6 : 5)-1:0]        paddr,
  input  logic [(COEF_WIDTH > 32 ? 64 : 32)-1:0]      pwdata,
  output logic [(COEF_WIDTH > 32 ? 64 : 32)-1:0]      prdata,
  output logic                                        pready
);

  localparam int CW    = COEF_WIDTH;
  localparam int PAW   = (CW > 32) ? 6 : 5;
  localparam int PDW   = (CW > 32) ? 64 : 32;
  localparam int NUM_W = aicm_pkg::num_width(COEF_WIDTH, DIM_BITS);
  localparam int DEN_W = aicm_pkg::den_width(COEF_WIDTH, DIM_BITS);

  // Configuration registers.
  logic [CW-1:0] coef_q [6];
  logic [31:0]   src_dims_q, dst_dims_q;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PAW-1 -: 3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0]  <= CW'(aicm_pkg::COEF_ONE);
      coef_q[1]  <= '0;
      coef_q[2]  <= '0;
      coef_q[3]  <= '0;
      coef_q[4]  <= CW'(aicm_pkg::COEF_ONE);
      coef_q[5]  <= '0;
      src_dims_q <= aicm_pkg::DIMS_RESET;
      dst_dims_q <= aicm_pkg::DIMS_RESET;
    end else if (wr_en) begin
      case (aicm_pkg::reg_idx_e'(reg_idx))
        aicm_pkg::REG_COEF_A:   coef_q[0]  <= pwdata[CW-1:0];
        aicm_pkg::REG_COEF_B:   coef_q[1]  <= pwdata[CW-1:0];
        aicm_pkg::REG_COEF_C:   coef_q[2]  <= pwdata[CW-1:0];
        aicm_pkg::REG_COEF_D:   coef_q[3]  <= pwdata[CW-1:0];
        aicm_pkg::REG_COEF_E:   coef_q[4]  <= pwdata[CW-1:0];
        aicm_pkg::REG_COEF_F:   coef_q[5]  <= pwdata[CW-1:0];
        aicm_pkg::REG_SRC_DIMS: src_dims_q <= pwdata[31:0];
        aicm_pkg::REG_DST_DIMS: dst_dims_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (aicm_pkg::reg_idx_e'(reg_idx))
      aicm_pkg::REG_COEF_A:   prdata = PDW'(coef_q[0]);
      aicm_pkg::REG_COEF_B:   prdata = PDW'(coef_q[1]);
      aicm_pkg::REG_COEF_C:   prdata = PDW'(coef_q[2]);
      aicm_pkg::REG_COEF_D:   prdata = PDW'(coef_q[3]);
      aicm_pkg::REG_COEF_E:   prdata = PDW'(coef_q[4]);
      aicm_pkg::REG_COEF_F:   prdata = PDW'(coef_q[5]);
      aicm_pkg::REG_SRC_DIMS: prdata = PDW'(src_dims_q);
      aicm_pkg::REG_DST_DIMS: prdata = PDW'(dst_dims_q);
      default:                prdata = '0;
    endcase
  end

  // The pipeline moves as one whenever the output register can be loaded.
  logic en;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Front end.
  logic                  f_valid;
  logic [NUM_W-1:0]      num_x, num_y;
  logic [DEN_W-1:0]      den_x, den_y;
  aicm_pkg::axis_flags_t flags_x, flags_y;

  aicm_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .DIM_BITS   (DIM_BITS),
    .NUM_W      (NUM_W),
    .DEN_W      (DEN_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .norm_x_i   (s_axis_tdata[16:0]),
    .norm_y_i   (s_axis_tdata[33:17]),
    .coef_a_i   ($signed(coef_q[0])),
    .coef_b_i   ($signed(coef_q[1])),
    .coef_c_i   ($signed(coef_q[2])),
    .coef_d_i   ($signed(coef_q[3])),
    .coef_e_i   ($signed(coef_q[4])),
    .coef_f_i   ($signed(coef_q[5])),
    .src_dims_i (src_dims_q),
    .dst_dims_i (dst_dims_q),
    .valid_o    (f_valid),
    .num_x_o    (num_x),
    .den_x_o    (den_x),
    .flags_x_o  (flags_x),
    .num_y_o    (num_y),
    .den_y_o    (den_y),
    .flags_y_o  (flags_y)
  );

  // One divider per axis.
  logic        valid_x, valid_y;
  logic [31:0] res_x, res_y;
  logic        fault_x, fault_y, sing_x, sing_y;

  aicm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .num_i      (num_x),
    .den_i      (den_x),
    .flags_i    (flags_x),
    .valid_o    (valid_x),
    .res_o      (res_x),
    .fault_o    (fault_x),
    .singular_o (sing_x)
  );

  aicm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .num_i      (num_y),
    .den_i      (den_y),
    .flags_i    (flags_y),
    .valid_o    (valid_y),
    .res_o      (res_y),
    .fault_o    (fault_y),
    .singular_o (sing_y)
  );

  // Result transaction.
  assign m_axis_tvalid = valid_x;
  assign m_axis_tdata  = {res_y, res_x};
  assign m_axis_tuser  = {fault_x | fault_y, sing_x & sing_y};

  `AICM_ASSERT(a_sing_out, m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata[31:0] == aicm_pkg::SING_VALUE)
  `AICM_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready)
  `AICM_ASSERT(a_stall_blocks, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
  `AICM_ASSERT(a_axes_lock, valid_x == valid_y && (!valid_x || sing_x == sing_y))
  `AICM_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid)

endmodule
